### src/tkpd_pkg.sv
// ----------------------------------------------------------------------------
// tkpd_pkg
// Shared codes, widths and types for the two-key press detector.
// ----------------------------------------------------------------------------
package tkpd_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_W      = 8;
  localparam int HOLD_W     = 16;
  localparam int KEY_W      = 2;
  localparam int EVENT_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SCAN_DIVIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_SCANS  = 1'd1;

  localparam logic [DIV_W-1:0]  RESET_SCAN_DIVIDE = 8'd20;
  localparam logic [HOLD_W-1:0] RESET_LONG_SCANS  = 16'd5;
  localparam logic [HOLD_W-1:0] HOLD_MAX          = 16'hFFFF;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic PIN_PRESSED = 1'b0;

  localparam logic [KEY_W-1:0] KEY_NONE = 2'd0;
  localparam logic [KEY_W-1:0] KEY_1    = 2'd1;
  localparam logic [KEY_W-1:0] KEY_2    = 2'd2;

  localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EVENT_W-1:0] EV_K1_SHORT = 3'd1;
  localparam logic [EVENT_W-1:0] EV_K1_LONG  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_K2_SHORT = 3'd3;
  localparam logic [EVENT_W-1:0] EV_K2_LONG  = 3'd4;

  typedef struct packed {
    logic command;
    logic key1_level;
    logic key2_level;
  } in_item_t;

  typedef struct packed {
    logic     fire;
    in_item_t item;
  } core_req_t;

  typedef struct packed {
    logic               valid;
    logic [EVENT_W-1:0] event_code;
  } core_res_t;

endpackage

### src/tkpd_ifs.sv
// ----------------------------------------------------------------------------
// tkpd_ifs
// Request and result channels of the two-key press detector.
// ----------------------------------------------------------------------------
interface tkpd_in_if;
  logic valid;
  logic ready;
  logic command;
  logic key1_level;
  logic key2_level;

  modport source (output valid, output command, output key1_level, output key2_level,
                  input ready);
  modport sink   (input valid, input command, input key1_level, input key2_level,
                  output ready);
endinterface

interface tkpd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

### src/tkpd_in_stage.sv
// ----------------------------------------------------------------------------
// tkpd_in_stage
// Input register: holds one request until the core takes it.
// ----------------------------------------------------------------------------
module tkpd_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  tkpd_pkg::in_item_t  req_item,
  input  logic                advance,
  output tkpd_pkg::core_req_t core_req
);
  import tkpd_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign req_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (req_ready) begin
      valid_nxt = req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      item_r <= req_item;
    end
  end

  assign core_req.fire = valid_r && advance;
  assign core_req.item = item_r;

endmodule

### src/tkpd_core.sv
// ----------------------------------------------------------------------------
// tkpd_core
// Configuration registers, key scan state and event generation.
// ----------------------------------------------------------------------------
module tkpd_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tkpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tkpd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  tkpd_pkg::core_req_t               core_req,
  output tkpd_pkg::core_res_t               core_res
);
  import tkpd_pkg::*;

  logic [DIV_W-1:0]   scan_divide_r;
  logic [HOLD_W-1:0]  long_scans_r;
  logic [DIV_W-1:0]   prescale_r,  prescale_nxt;
  logic [KEY_W-1:0]   cur_key_r,   cur_key_nxt;
  logic [KEY_W-1:0]   prev_key_r,  prev_key_nxt;
  logic [HOLD_W-1:0]  hold_r,      hold_nxt;
  logic               long_done_r, long_done_nxt;
  logic [EVENT_W-1:0] pending_r,   pending_nxt;
  logic [DIV_W-1:0]   tick_inc;
  logic [HOLD_W-1:0]  hold_inc;
  logic [KEY_W-1:0]   key_now;
  logic [EVENT_W-1:0] long_ev;
  logic [EVENT_W-1:0] short_ev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_divide_r <= RESET_SCAN_DIVIDE;
      long_scans_r  <= RESET_LONG_SCANS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCAN_DIVIDE: scan_divide_r <= cfg_wdata[DIV_W-1:0];
        REG_LONG_SCANS:  long_scans_r  <= cfg_wdata[HOLD_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    if (core_req.item.key1_level == PIN_PRESSED) begin
      key_now = KEY_1;
    end else if (core_req.item.key2_level == PIN_PRESSED) begin
      key_now = KEY_2;
    end else begin
      key_now = KEY_NONE;
    end
  end

  always_comb begin
    case (key_now)
      KEY_1:   long_ev = EV_K1_LONG;
      KEY_2:   long_ev = EV_K2_LONG;
      default: long_ev = EV_NONE;
    endcase
    case (cur_key_r)
      KEY_1:   short_ev = EV_K1_SHORT;
      KEY_2:   short_ev = EV_K2_SHORT;
      default: short_ev = EV_NONE;
    endcase
  end

  assign tick_inc = prescale_r + 8'd1;
  assign hold_inc = (hold_r == HOLD_MAX) ? hold_r : hold_r + 16'd1;

  always_comb begin
    prescale_nxt  = prescale_r;
    cur_key_nxt   = cur_key_r;
    prev_key_nxt  = prev_key_r;
    hold_nxt      = hold_r;
    long_done_nxt = long_done_r;
    pending_nxt   = pending_r;
    core_res.valid      = core_req.fire;
    core_res.event_code = EV_NONE;
    if (core_req.fire) begin
      if (core_req.item.command == CMD_READ) begin
        core_res.event_code = pending_r;
        pending_nxt         = EV_NONE;
      end else if (tick_inc < scan_divide_r) begin
        prescale_nxt = tick_inc;
      end else begin
        prescale_nxt = '0;
        prev_key_nxt = cur_key_r;
        cur_key_nxt  = key_now;
        if (key_now != KEY_NONE) begin
          hold_nxt = hold_inc;
          if (hold_inc >= long_scans_r && !long_done_r) begin
            long_done_nxt = 1'b1;
            pending_nxt   = long_ev;
          end
        end else begin
          if (cur_key_r != KEY_NONE && !long_done_r) begin
            pending_nxt = short_ev;
          end
          hold_nxt      = '0;
          long_done_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r  <= '0;
      cur_key_r   <= KEY_NONE;
      prev_key_r  <= KEY_NONE;
      hold_r      <= '0;
      long_done_r <= 1'b0;
      pending_r   <= EV_NONE;
    end else begin
      prescale_r  <= prescale_nxt;
      cur_key_r   <= cur_key_nxt;
      prev_key_r  <= prev_key_nxt;
      hold_r      <= hold_nxt;
      long_done_r <= long_done_nxt;
      pending_r   <= pending_nxt;
    end
  end

endmodule

### src/tkpd_out_stage.sv
// ----------------------------------------------------------------------------
// tkpd_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module tkpd_out_stage (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tkpd_pkg::core_res_t                core_res,
  output logic                               advance,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic [tkpd_pkg::EVENT_W-1:0]       res_event_code
);
  import tkpd_pkg::*;

  logic               valid_r;
  logic               valid_nxt;
  logic [EVENT_W-1:0] code_r;

  assign advance = !valid_r || res_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res.valid) begin
      code_r <= core_res.event_code;
    end
  end

  assign res_valid      = valid_r;
  assign res_event_code = code_r;

endmodule

### src/two_key_short_long_press_detector_unit.sv
// ----------------------------------------------------------------------------
// two_key_short_long_press_detector_unit
// Two-key short/long press detector with request and result channels.
// ----------------------------------------------------------------------------
// Each request is a tick carrying both active-low pin levels, or a read that
// returns and clears the pending event; every request gives one result. A
// request passes an input register, one pass of scan and event logic, and a
// result register: one request per cycle is taken while the result side keeps
// up, and its result is loaded into the result register, which holds it until
// the result side takes it. Configuration writes (register 0 scan_divide,
// register 1 long_press_scans) take effect on the next request; the caller must
// make them while no request is in flight, which the block does not enforce.
module two_key_short_long_press_detector_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  tkpd_in_if.sink                           in_ch,
  tkpd_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [tkpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tkpd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tkpd_pkg::*;

  in_item_t  in_item;
  core_req_t core_req;
  core_res_t core_res;
  logic      advance;

  assign in_item.command    = in_ch.command;
  assign in_item.key1_level = in_ch.key1_level;
  assign in_item.key2_level = in_ch.key2_level;

  tkpd_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_ch.valid),
    .req_ready (in_ch.ready),
    .req_item  (in_item),
    .advance   (advance),
    .core_req  (core_req)
  );

  tkpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .core_req  (core_req),
    .core_res  (core_res)
  );

  tkpd_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .core_res       (core_res),
    .advance        (advance),
    .res_valid      (out_ch.valid),
    .res_ready      (out_ch.ready),
    .res_event_code (out_ch.event_code)
  );

endmodule

### test/two_key_short_long_press_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// two_key_short_long_press_detector_unit_tb
// Drives tick and read requests into the press detector. A scoreboard
// predicts every event code and compares each result in order. A directed
// set of requests comes first, then random press gestures under changing
// scan and threshold settings, with random stalls on both channels. A final
// run with the scan divider at its maximum closes the test.
// ----------------------------------------------------------------------------
import tkpd_pkg::*;

class key_event_scoreboard;
  logic [DIV_W-1:0]   scan_div;
  logic [HOLD_W-1:0]  long_thr;
  logic [DIV_W-1:0]   prescale;
  logic [KEY_W-1:0]   cur_key;
  logic [KEY_W-1:0]   prev_key;
  logic [HOLD_W-1:0]  held;
  bit                 long_fired;
  logic [EVENT_W-1:0] pending;
  logic [EVENT_W-1:0] expected_events[$];
  int                 accepted;
  int                 errors;

  function new();
    scan_div   = RESET_SCAN_DIVIDE;
    long_thr   = RESET_LONG_SCANS;
    prescale   = '0;
    cur_key    = KEY_NONE;
    prev_key   = KEY_NONE;
    held       = '0;
    long_fired = 1'b0;
    pending    = EV_NONE;
    accepted   = 0;
    errors     = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_SCAN_DIVIDE) begin
      scan_div = data[DIV_W-1:0];
    end else begin
      long_thr = data[HOLD_W-1:0];
    end
  endfunction

  function void note_request(in_item_t req);
    logic [KEY_W-1:0] key;
    accepted++;
    if (req.command == CMD_READ) begin
      expected_events.push_back(pending);
      pending = EV_NONE;
      return;
    end
    expected_events.push_back(EV_NONE);
    prescale = prescale + 1'b1;
    if (prescale < scan_div) return;
    prescale = '0;
    if (req.key1_level == PIN_PRESSED) key = KEY_1;
    else if (req.key2_level == PIN_PRESSED) key = KEY_2;
    else key = KEY_NONE;
    prev_key = cur_key;
    cur_key  = key;
    if (cur_key != KEY_NONE) begin
      if (held != HOLD_MAX) held = held + 1'b1;
      if (held >= long_thr && !long_fired) begin
        long_fired = 1'b1;
        pending = (cur_key == KEY_1) ? EV_K1_LONG : EV_K2_LONG;
      end
    end else begin
      if (prev_key != KEY_NONE && !long_fired)
        pending = (prev_key == KEY_1) ? EV_K1_SHORT : EV_K2_SHORT;
      held       = '0;
      long_fired = 1'b0;
    end
  endfunction

  function void check_result(logic [EVENT_W-1:0] code);
    logic [EVENT_W-1:0] want;
    if (expected_events.size() == 0) begin
      errors++;
      if (errors <= 10) $display("result with no request waiting: event_code %0d", code);
      return;
    end
    want = expected_events.pop_front();
    if (code !== want) begin
      errors++;
      if (errors <= 10)
        $display("event_code mismatch at %0t: expected %0d, got %0d", $time, want, code);
    end
  endfunction

  function int outstanding();
    return expected_events.size();
  endfunction

  function bit failed();
    return errors != 0 || expected_events.size() != 0;
  endfunction
endclass

module two_key_short_long_press_detector_unit_tb;
  localparam logic PIN_OPEN = ~PIN_PRESSED;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  int sink_hold_left = 0;
  key_event_scoreboard sb;

  tkpd_in_if  in_ch();
  tkpd_out_if out_ch();

  two_key_short_long_press_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task send_request(input logic cmd, input logic k1, input logic k2);
    in_item_t req;
    while (src_idle_en && $urandom_range(0, 99) < 30) begin
      @(negedge clk);
      in_ch.valid      = 1'b0;
      in_ch.command    = 1'($urandom_range(0, 1));
      in_ch.key1_level = 1'($urandom_range(0, 1));
      in_ch.key2_level = 1'($urandom_range(0, 1));
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.command    = cmd;
    in_ch.key1_level = k1;
    in_ch.key2_level = k2;
    do @(posedge clk); while (!in_ch.ready);
    req.command    = cmd;
    req.key1_level = k1;
    req.key2_level = k2;
    sb.note_request(req);
  endtask

  task tick_keys(input logic k1, input logic k2);
    send_request(CMD_TICK, k1, k2);
  endtask

  task read_event();
    send_request(CMD_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, data);
  endtask

  task press_gesture(input int divider, input int threshold);
    int   period, hold_ticks, rel_ticks, mode, i;
    logic k1, k2;
    period     = (divider == 0) ? 1 : divider;
    hold_ticks = $urandom_range(1, (threshold > 6 ? 6 : threshold) + 2) * period
                 + $urandom_range(0, period - 1);
    rel_ticks  = $urandom_range(1, 3) * period;
    mode       = $urandom_range(0, 9);
    for (i = 0; i < hold_ticks; i++) begin
      case (mode)
        0, 1, 2, 3: begin
          k1 = PIN_PRESSED;
          k2 = 1'($urandom_range(0, 1));
        end
        4, 5, 6: begin
          k1 = PIN_OPEN;
          k2 = PIN_PRESSED;
        end
        7: begin
          k1 = PIN_PRESSED;
          k2 = PIN_PRESSED;
        end
        8: begin
          k1 = (i < hold_ticks / 2) ? PIN_PRESSED : PIN_OPEN;
          k2 = PIN_PRESSED;
        end
        default: begin
          k1 = 1'($urandom_range(0, 1));
          k2 = 1'($urandom_range(0, 1));
        end
      endcase
      if ($urandom_range(0, 9) == 0) read_event();
      tick_keys(k1, k2);
    end
    for (i = 0; i < rel_ticks; i++) begin
      if ($urandom_range(0, 19) == 0) tick_keys(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      else tick_keys(PIN_OPEN, PIN_OPEN);
    end
    if ($urandom_range(0, 3) != 0) read_event();
  endtask

  task run_phase(input int divider, input int threshold, input int n_req, input bit stall);
    int start;
    drain_results();
    write_reg(REG_SCAN_DIVIDE, CFG_DATA_W'(divider));
    write_reg(REG_LONG_SCANS, CFG_DATA_W'(threshold));
    if (stall) sink_hold_left = 80;
    start = sb.accepted;
    while (sb.accepted - start < n_req) press_gesture(divider, threshold);
  endtask

  // result side: random stalls plus an optional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_left > 0) begin
        out_ch.ready = 1'b0;
        sink_hold_left--;
      end else begin
        out_ch.ready = !(snk_idle_en && $urandom_range(0, 99) < 30);
      end
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.event_code);
    end
  end

  initial begin
    int i;
    sb = new();
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_TICK;
    in_ch.key1_level = PIN_OPEN;
    in_ch.key2_level = PIN_OPEN;
    cfg_we    = 1'b0;
    cfg_index = REG_SCAN_DIVIDE;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    read_event();
    tick_keys(PIN_OPEN, PIN_OPEN);
    tick_keys(PIN_PRESSED, PIN_OPEN);
    drain_results();
    write_reg(REG_SCAN_DIVIDE, CFG_DATA_W'(1));
    write_reg(REG_LONG_SCANS, CFG_DATA_W'(2));
    tick_keys(PIN_PRESSED, PIN_OPEN);
    tick_keys(PIN_OPEN, PIN_OPEN);
    read_event();
    read_event();
    tick_keys(PIN_OPEN, PIN_PRESSED);
    tick_keys(PIN_OPEN, PIN_OPEN);
    tick_keys(PIN_PRESSED, PIN_PRESSED);
    tick_keys(PIN_PRESSED, PIN_PRESSED);
    tick_keys(PIN_OPEN, PIN_OPEN);
    read_event();
    tick_keys(PIN_PRESSED, PIN_OPEN);
    tick_keys(PIN_OPEN, PIN_PRESSED);
    tick_keys(PIN_OPEN, PIN_OPEN);
    read_event();
    drain_results();
    write_reg(REG_LONG_SCANS, CFG_DATA_W'(0));
    tick_keys(PIN_OPEN, PIN_PRESSED);
    tick_keys(PIN_OPEN, PIN_OPEN);
    read_event();
    drain_results();
    write_reg(REG_LONG_SCANS, CFG_DATA_W'(5));
    write_reg(REG_SCAN_DIVIDE, CFG_DATA_W'(0));
    tick_keys(PIN_PRESSED, PIN_OPEN);
    tick_keys(PIN_OPEN, PIN_PRESSED);
    tick_keys(PIN_OPEN, PIN_OPEN);
    read_event();
    drain_results();
    write_reg(REG_SCAN_DIVIDE, CFG_DATA_W'(10));
    for (i = 0; i < 6; i++) tick_keys(PIN_PRESSED, PIN_OPEN);
    drain_results();
    write_reg(REG_SCAN_DIVIDE, CFG_DATA_W'(3));
    tick_keys(PIN_PRESSED, PIN_OPEN);
    for (i = 0; i < 3; i++) tick_keys(PIN_OPEN, PIN_OPEN);
    read_event();

    run_phase(2, 4, 200, 1'b1);
    run_phase(1, 0, 120, 1'b0);
    run_phase(0, 1, 120, 1'b0);
    drain_results();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    run_phase(3, 2, 120, 1'b0);
    drain_results();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    run_phase(1, 65535, 80, 1'b0);
    run_phase(5, 7, 120, 1'b1);
    run_phase(1, 3, 120, 1'b0);

    // scan divider at its maximum: one long press of key 2, then release
    drain_results();
    write_reg(REG_SCAN_DIVIDE, CFG_DATA_W'(255));
    write_reg(REG_LONG_SCANS, CFG_DATA_W'(1));
    for (i = 0; i < 255; i++) tick_keys(PIN_OPEN, PIN_PRESSED);
    read_event();
    for (i = 0; i < 255; i++) tick_keys(PIN_OPEN, PIN_OPEN);
    read_event();

    drain_results();
    repeat (10) @(posedge clk);
    if (!sb.failed()) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #(12 * 600000);
    $display("TB_ERROR");
    $finish;
  end
endmodule

### two_key_short_long_press_detector_unit.f
src/tkpd_pkg.sv
src/tkpd_ifs.sv
src/tkpd_in_stage.sv
src/tkpd_core.sv
src/tkpd_out_stage.sv
src/two_key_short_long_press_detector_unit.sv
test/two_key_short_long_press_detector_unit_tb.sv
